/* rtl/url_percent_decoder_top_defines.svh */
// Assertion macros shared by the percent decoder RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef URL_PERCENT_DECODER_TOP_DEFINES_SVH
`define URL_PERCENT_DECODER_TOP_DEFINES_SVH

// Invariant checked at every clock edge out of reset.
`define UPD_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define UPD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define UPD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/upd_pkg.sv */
// Shared types, constants and helpers for the percent decoder.
// No dependencies.
`default_nettype none

package upd_pkg;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// One decoded request: up to three output bytes from one input byte.
	typedef struct packed {
		logic [1:0]      cnt;
		logic [2:0][7:0] bytes;
		logic            last;
	} cmd_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) ||
			(c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46);
	endfunction

	// Letters map to low nibble + 9 for both cases.
	function automatic logic [3:0] hex_nib(input logic [7:0] c);
		return (c[6]) ? (c[3:0] + 4'd9) : c[3:0];
	endfunction

	function automatic cmd_t push_byte(input cmd_t c, input logic [7:0] b);
		cmd_t r;
		r = c;
		if (c.cnt != 2'd3) begin
			r.bytes[c.cnt] = b;
			r.cnt = c.cnt + 2'd1;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/upd_front.sv */
// Front end: accepts input bytes, tracks escape state, builds output requests.
// Depends on upd_pkg and the assertion macro header.
`default_nettype none

`include "url_percent_decoder_top_defines.svh"

module upd_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    in_byte,
	input  wire logic          in_last,
	input  wire logic          q_full,
	output logic               push,
	output upd_pkg::cmd_t      push_cmd
);
	import upd_pkg::*;

	typedef enum logic [1:0] {
		P_NONE = 2'd0,
		P_PCT  = 2'd1,
		P_DIG  = 2'd2
	} pend_t;

	pend_t      pend_q, pend_d;
	logic [7:0] held_q, held_d;
	logic       do_plain;
	logic       accept;
	cmd_t       cmd;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd      = '0;
		pend_d   = pend_q;
		held_d   = held_q;
		do_plain = 1'b0;
		unique case (pend_q)
			P_PCT: begin
				if (is_hex(in_byte)) begin
					held_d = in_byte;
					pend_d = P_DIG;
				end else begin
					cmd      = push_byte(cmd, CH_PERCENT);
					pend_d   = P_NONE;
					do_plain = 1'b1;
				end
			end
			P_DIG: begin
				if (is_hex(in_byte) && is_hex(held_q)) begin
					cmd    = push_byte(cmd, {hex_nib(held_q), hex_nib(in_byte)});
					pend_d = P_NONE;
				end else begin
					// bad second digit: '%' and held digit go out literally
					cmd      = push_byte(cmd, CH_PERCENT);
					cmd      = push_byte(cmd, held_q);
					pend_d   = P_NONE;
					do_plain = 1'b1;
				end
			end
			default: begin
				pend_d   = P_NONE;
				do_plain = 1'b1;
			end
		endcase
		if (do_plain) begin
			if (in_byte == CH_PERCENT) begin
				pend_d = P_PCT;
			end else if (in_byte == CH_PLUS) begin
				cmd = push_byte(cmd, CH_SPACE);
			end else begin
				cmd = push_byte(cmd, in_byte);
			end
		end
		// flush an unfinished escape at end of string
		if (in_last) begin
			if (pend_d != P_NONE) begin
				cmd = push_byte(cmd, CH_PERCENT);
			end
			if (pend_d == P_DIG) begin
				cmd = push_byte(cmd, held_d);
			end
			pend_d = P_NONE;
			held_d = 8'h00;
		end
		cmd.last = in_last;
	end

	assign push     = accept && (cmd.cnt != 2'd0);
	assign push_cmd = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= P_NONE;
			held_q <= 8'h00;
		end else if (accept) begin
			pend_q <= pend_d;
			held_q <= held_d;
		end
	end

	`UPD_ASSERT_NEXT(a_last_clears_pend, accept && in_last, pend_q == P_NONE, "pending state survived last byte")
	`UPD_ASSERT_IMPL(a_last_pushes, accept && in_last, push, "last byte produced no request")

endmodule

`default_nettype wire

/* rtl/upd_queue.sv */
// Short request queue between front and back ends, register-file based.
// Depends on upd_pkg and the assertion macro header.
`default_nettype none

`include "url_percent_decoder_top_defines.svh"

module upd_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire upd_pkg::cmd_t push_cmd,
	input  wire logic          pop,
	output logic               full,
	output logic               empty,
	output upd_pkg::cmd_t      head
);
	import upd_pkg::*;

	cmd_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QAW:0]   cnt_q;

	assign full  = (cnt_q == (QAW+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH-1)) ? '0 : wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH-1)) ? '0 : rd_ptr_q + QAW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QAW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QAW+1)'(1);
			end
		end
	end

	`UPD_ASSERT_IMPL(a_no_overflow, push, !full, "push into full queue")
	`UPD_ASSERT_IMPL(a_no_underflow, pop, !empty, "pop from empty queue")

endmodule

`default_nettype wire

/* rtl/upd_back.sv */
// Back end: walks head request, one byte per cycle while out_ready.
// Depends on upd_pkg and the assertion macro header.
`default_nettype none

`include "url_percent_decoder_top_defines.svh"

module upd_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          empty,
	input  wire upd_pkg::cmd_t head,
	output logic               pop,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [7:0]         out_byte,
	output logic               out_last
);
	import upd_pkg::*;

	logic [1:0] idx_q;
	logic       final_byte;

	assign final_byte = (idx_q == head.cnt - 2'd1);
	assign out_valid  = !empty;
	assign out_byte   = head.bytes[idx_q];
	assign out_last   = head.last && final_byte;
	assign pop        = out_valid && out_ready && final_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (out_valid && out_ready) begin
			idx_q <= final_byte ? 2'd0 : idx_q + 2'd1;
		end
	end

	`UPD_ASSERT_IMPL(a_cnt_nonzero, !empty, head.cnt != 2'd0, "empty request in queue")
	`UPD_ASSERT_IMPL(a_idx_range, !empty, idx_q < head.cnt, "byte index beyond request")

endmodule

`default_nettype wire

/* rtl/url_percent_decoder_top.sv */
// A decoded request is registered in the request queue and read out from its head.
// Throughput: one input byte per cycle, stalling only when the 4-entry request queue
// is full; the back end gives one output byte per cycle while out_ready is high, so
// the queue absorbs inputs that decode to more than one byte.
// Reset: arst_n asynchronously clears escape state, queue pointers and byte index.
`default_nettype none

module url_percent_decoder_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            out_last
);
	import upd_pkg::*;

	logic q_full, q_empty, q_push, q_pop;
	cmd_t push_cmd, head;

	upd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.q_full   (q_full),
		.push     (q_push),
		.push_cmd (push_cmd)
	);

	upd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (head)
	);

	upd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (q_empty),
		.head      (head),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for url_percent_decoder_top: byte stream in, decoded bytes out.
// Uses upd_pkg for the character constants. Checks every output against an in-bench
// decoder model, with random stalls on both sides.
`timescale 1ns / 1ps

module testbench;
	import upd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 64;
	localparam int DRAIN_CYCLES = 20;
	localparam int REPORT_MAX = 10;

	// Tracks escape state and holds the decoded bytes still owed by the block.
	class url_decode_scoreboard;
		logic [1:0] escape_phase;
		logic [7:0] held_hex;
		logic [8:0] decoded_q[$]; // {last, byte}
		int step_count;
		int fail_count;

		function new();
			escape_phase = 2'd0;
			held_hex = 8'h00;
			fail_count = 0;
		endfunction

		function bit hex_val(input logic [7:0] c, output logic [3:0] v);
			if (c >= 8'h30 && c <= 8'h39) begin
				v = 4'(c - 8'h30);
			end else if (c >= 8'h61 && c <= 8'h66) begin
				v = 4'(c - 8'h61 + 8'd10);
			end else if (c >= 8'h41 && c <= 8'h46) begin
				v = 4'(c - 8'h41 + 8'd10);
			end else begin
				return 1'b0;
			end
			return 1'b1;
		endfunction

		function void emit(input logic [7:0] c);
			if (step_count < 3) begin
				decoded_q.insert(decoded_q.size(), {1'b0, c});
				step_count++;
			end
		endfunction

		function void take_plain(input logic [7:0] c);
			if (c == CH_PERCENT) begin
				escape_phase = 2'd1;
			end else if (c == CH_PLUS) begin
				emit(CH_SPACE);
			end else begin
				emit(c);
			end
		endfunction

		function void note_encoded(input logic [7:0] ch, input logic is_last);
			logic [3:0] hi;
			logic [3:0] lo;
			step_count = 0;
			case (escape_phase)
				2'd1: begin
					if (hex_val(ch, hi)) begin
						held_hex = ch;
						escape_phase = 2'd2;
					end else begin
						emit(CH_PERCENT);
						escape_phase = 2'd0;
						take_plain(ch);
					end
				end
				2'd2: begin
					if (hex_val(ch, lo) && hex_val(held_hex, hi)) begin
						emit({hi, lo});
						escape_phase = 2'd0;
					end else begin
						emit(CH_PERCENT);
						escape_phase = 2'd0;
						take_plain(held_hex);
						take_plain(ch);
					end
				end
				default: begin
					escape_phase = 2'd0;
					take_plain(ch);
				end
			endcase
			if (is_last) begin
				// flush a half-seen escape as literals
				if (escape_phase >= 2'd1)
					emit(CH_PERCENT);
				if (escape_phase == 2'd2)
					emit(held_hex);
				escape_phase = 2'd0;
				held_hex = 8'h00;
				if (step_count > 0)
					decoded_q[decoded_q.size() - 1][8] = 1'b1;
			end
		endfunction

		function void flag(input string what, input logic [8:0] want, input logic [8:0] got);
			fail_count++;
			if (fail_count <= REPORT_MAX)
				$display("mismatch (%s): expected byte %h last %b, got byte %h last %b",
					what, want[7:0], want[8], got[7:0], got[8]);
		endfunction

		function void check_decoded(input logic [7:0] ch, input logic is_last);
			logic [8:0] want;
			if (decoded_q.size() == 0) begin
				flag("nothing expected", 9'h000, {is_last, ch});
			end else begin
				want = decoded_q.pop_front();
				if (want[7:0] !== ch || want[8] !== is_last)
					flag("wrong field", want, {is_last, ch});
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [7:0] in_byte;
	logic in_last;
	logic out_valid;
	logic out_ready;
	logic [7:0] out_byte;
	logic out_last;

	int send_idle_pct;
	int recv_idle_pct;
	bit hold_request;
	int items_sent;
	int cycle_count;

	url_decode_scoreboard sb = new();

	url_percent_decoder_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.in_last(in_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.out_last(out_last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_encoded(in_byte, in_last);
			if (out_valid && out_ready)
				sb.check_decoded(out_byte, out_last);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Receiver: random back-pressure, plus one long hold-off on request.
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (hold_request) begin
				hold_request = 1'b0;
				stall_left = HOLD_CYCLES - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_request(input logic [7:0] ch, input logic is_last);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= ch;
		in_last <= is_last;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic send_string(input logic [7:0] text_q[$]);
		foreach (text_q[i])
			send_request(text_q[i], i == text_q.size() - 1);
	endtask

	task automatic send_text(input string s);
		logic [7:0] text_q[$];
		for (int i = 0; i < s.len(); i++)
			text_q.insert(text_q.size(), s[i]);
		send_string(text_q);
	endtask

	function automatic logic [7:0] rand_hex();
		logic [7:0] d;
		d = 8'($urandom_range(21));
		if (d < 8'd10)
			return 8'h30 + d;
		else if (d < 8'd16)
			return 8'h61 + d - 8'd10;
		return 8'h41 + d - 8'd16;
	endfunction

	// Mostly well-formed strings; some broken escapes and arbitrary bytes.
	task automatic send_random_string();
		logic [7:0] text_q[$];
		int tokens;
		int r;
		tokens = $urandom_range(1, 8);
		for (int t = 0; t < tokens; t++) begin
			r = $urandom_range(99);
			if (r < 40) begin
				text_q.insert(text_q.size(), CH_PERCENT);
				text_q.insert(text_q.size(), rand_hex());
				text_q.insert(text_q.size(), rand_hex());
			end else if (r < 55) begin
				text_q.insert(text_q.size(), CH_PLUS);
			end else if (r < 75) begin
				text_q.insert(text_q.size(), 8'($urandom_range(8'h21, 8'h7E)));
			end else if (r < 85) begin
				text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
			end else if (r < 92) begin
				text_q.insert(text_q.size(), CH_PERCENT);
				text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
			end else begin
				text_q.insert(text_q.size(), CH_PERCENT);
				text_q.insert(text_q.size(), rand_hex());
				text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
			end
		end
		// sometimes end mid-escape
		r = $urandom_range(99);
		if (r < 6) begin
			text_q.insert(text_q.size(), CH_PERCENT);
		end else if (r < 12) begin
			text_q.insert(text_q.size(), CH_PERCENT);
			text_q.insert(text_q.size(), rand_hex());
		end
		send_string(text_q);
	endtask

	task automatic run_random(input int count);
		int stop_at;
		stop_at = items_sent + count;
		while (items_sent < stop_at)
			send_random_string();
	endtask

	initial begin
		logic [7:0] edge_q[$];
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_byte = 8'h00;
		in_last = 1'b0;
		hold_request = 1'b0;
		items_sent = 0;
		cycle_count = 0;
		send_idle_pct = 17;
		recv_idle_pct = 78;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		edge_q = '{8'h00, 8'hFF};
		send_string(edge_q);
		send_text("+%41%aF%00");
		send_text("%G%4Z");
		send_text("%");
		send_text("%f");
		send_text("%%+");
		send_text("%4%");

		run_random(100);
		send_idle_pct = 78;
		recv_idle_pct = 17;
		run_random(100);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_request = 1'b1;
		run_random(100);

		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.decoded_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
